[rtl/smpd_pkg.sv]
// Shared types, codes and elaboration-time sine series helpers for the phase drive.
package smpd_pkg;

  localparam int ANGLE_W     = 32;
  localparam int CURRENT_W   = 16;
  localparam int DAC_W       = 8;
  localparam int BRIDGE_W    = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  typedef logic [BRIDGE_W-1:0] bridge_t;

  // H-bridge codes. BRIDGE_OFF also marks a zero coil value inside the pipeline.
  localparam bridge_t BRIDGE_OFF = 2'd0;
  localparam bridge_t BRIDGE_NEG = 2'd1;
  localparam bridge_t BRIDGE_POS = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_ENABLE     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_ROTATION = 8'd1;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF    = 64'sd536870912;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  // Taylor series of sin(x) to x^13, x in Q30 and within the first octant.
  function automatic longint sin_series_q30(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = q30_mul(x, x);
    term = x;
    sum  = x;
    term = q30_mul(term, x2) / 6;   sum = sum - term;
    term = q30_mul(term, x2) / 20;  sum = sum + term;
    term = q30_mul(term, x2) / 42;  sum = sum - term;
    term = q30_mul(term, x2) / 72;  sum = sum + term;
    term = q30_mul(term, x2) / 110; sum = sum - term;
    term = q30_mul(term, x2) / 156; sum = sum + term;
    return sum;
  endfunction

  // Taylor series of cos(x) to x^12, x in Q30 and within the first octant.
  function automatic longint cos_series_q30(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = q30_mul(x, x);
    term = Q30_ONE;
    sum  = Q30_ONE;
    term = q30_mul(term, x2) / 2;   sum = sum - term;
    term = q30_mul(term, x2) / 12;  sum = sum + term;
    term = q30_mul(term, x2) / 30;  sum = sum - term;
    term = q30_mul(term, x2) / 56;  sum = sum + term;
    term = q30_mul(term, x2) / 90;  sum = sum - term;
    term = q30_mul(term, x2) / 132; sum = sum + term;
    return sum;
  endfunction

  // Rounds a Q30 magnitude to the table scale and applies the quadrant sign.
  function automatic longint rom_entry(input longint v, input int quad, input longint peak);
    longint vv;
    longint mag;
    vv  = (v < 0) ? 64'sd0 : v;
    mag = (vv * peak + Q30_HALF) >>> 30;
    if (mag > peak) begin
      mag = peak;
    end
    return ((quad & 2) != 0) ? -mag : mag;
  endfunction

endpackage

[rtl/smpd_if.sv]
// Valid/ready channel interfaces for step items, results and register writes.
interface smpd_step_if;
  import smpd_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [ANGLE_W-1:0]   step_angle;
  logic        [CURRENT_W-1:0] current_ma;
  modport source (output valid, step_angle, current_ma, input ready);
  modport sink   (input valid, step_angle, current_ma, output ready);
endinterface

interface smpd_result_if;
  import smpd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] wrapped_angle;
  logic        [DAC_W-1:0]   dac_sine;
  logic        [DAC_W-1:0]   dac_cosine;
  bridge_t                   coil_a_bridge;
  bridge_t                   coil_b_bridge;
  modport source (output valid, wrapped_angle, dac_sine, dac_cosine, coil_a_bridge,
                  coil_b_bridge, input ready);
  modport sink   (input valid, wrapped_angle, dac_sine, dac_cosine, coil_a_bridge,
                  coil_b_bridge, output ready);
endinterface

interface smpd_cfg_if;
  import smpd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/smpd_wrap.sv]
// Three-stage reduction of a signed angle into one electrical period.
module smpd_wrap #(
  parameter int ANGLE_STEPS = 1024,
  parameter int AW          = $clog2(ANGLE_STEPS)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   angle,
  output logic [AW-1:0] wrapped
);
  import smpd_pkg::*;

  localparam longint RECIP_L = (longint'(1) << 32) / ANGLE_STEPS;
  localparam int     QEW     = $clog2(RECIP_L + 1);
  localparam int     RW      = AW + 1;
  localparam logic [QEW-1:0] RECIP    = QEW'(RECIP_L);
  localparam logic [RW-1:0]  N_R      = RW'(ANGLE_STEPS);
  localparam logic [RW-1:0]  OFFS     = RW'((longint'(1) << 31) % ANGLE_STEPS);
  localparam logic [RW-1:0]  N_M_OFFS = RW'(ANGLE_STEPS - ((longint'(1) << 31) % ANGLE_STEPS));

  logic [31:0]       u0;
  logic [31:0]       u1;
  logic [32+QEW-1:0] prod0;
  logic [QEW-1:0]    qe1;
  logic [RW-1:0]     qn;
  logic [RW-1:0]     rem2;
  logic [RW-1:0]     r3;
  logic [RW-1:0]     w3;

  // Bias to unsigned so that the quotient estimate is a plain multiply.
  assign u0    = angle ^ 32'h8000_0000;
  assign prod0 = (32+QEW)'(u0) * (32+QEW)'(RECIP);
  // The true remainder is below twice the period, so low bits suffice.
  assign qn    = RW'(qe1) * N_R;
  assign r3    = (rem2 >= N_R) ? (rem2 - N_R) : rem2;
  assign w3    = (r3 >= OFFS) ? (r3 - OFFS) : (r3 + N_M_OFFS);

  always_ff @(posedge clk) begin
    if (en) begin
      u1      <= u0;
      qe1     <= prod0[32+QEW-1:32];
      rem2    <= u1[RW-1:0] - qn;
      wrapped <= AW'(w3);
    end
  end

endmodule

[rtl/smpd_sine_rom.sv]
// Sine and cosine table, built at elaboration, with a registered read port.
module smpd_sine_rom #(
  parameter int ANGLE_STEPS = 1024,
  parameter int SINE_PEAK   = 32768,
  parameter int AW          = $clog2(ANGLE_STEPS),
  parameter int VW          = $clog2(SINE_PEAK + 1) + 1
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [VW-1:0] rd_sin,
  output logic signed [VW-1:0] rd_cos
);
  import smpd_pkg::*;

  logic [2*VW-1:0] rom_mem [ANGLE_STEPS];
  logic [2*VW-1:0] rd_word;

  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_entry
    localparam longint A     = 4 * longint'(k);
    localparam int     QUAD0 = int'((A / ANGLE_STEPS) & 3);
    localparam int     QUAD1 = (QUAD0 + 1) & 3;
    localparam longint R     = A % ANGLE_STEPS;
    localparam bit     LOW   = (2 * R <= ANGLE_STEPS);
    localparam longint RR    = LOW ? R : (ANGLE_STEPS - R);
    localparam longint X     = (HALF_PI_Q30 * RR) / ANGLE_STEPS;
    localparam longint SV    = sin_series_q30(X);
    localparam longint CV    = cos_series_q30(X);
    localparam longint BASE  = LOW ? SV : CV;
    localparam longint CO    = LOW ? CV : SV;
    localparam longint V_SIN = rom_entry(((QUAD0 & 1) != 0) ? CO : BASE, QUAD0, SINE_PEAK);
    localparam longint V_COS = rom_entry(((QUAD1 & 1) != 0) ? CO : BASE, QUAD1, SINE_PEAK);
    assign rom_mem[k] = {VW'(V_SIN), VW'(V_COS)};
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= rom_mem[rd_addr];
    end
  end

  assign rd_sin = $signed(rd_word[2*VW-1:VW]);
  assign rd_cos = $signed(rd_word[VW-1:0]);

endmodule

[rtl/smpd_cdiv.sv]
// Three-stage division by a fixed divisor using a reciprocal multiply and one correction.
module smpd_cdiv #(
  parameter int XW      = 32,
  parameter int DIVISOR = 32768,
  parameter int QW      = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q
);
  import smpd_pkg::*;

  localparam longint RECIP_L = (longint'(1) << XW) / DIVISOR;
  localparam int     RCW     = $clog2(RECIP_L + 1);
  localparam int     RMW     = $clog2(DIVISOR + 1) + 1;
  localparam logic [RCW-1:0] RECIP = RCW'(RECIP_L);
  localparam logic [RMW-1:0] DIV_R = RMW'(DIVISOR);

  logic [XW+RCW-1:0] prod;
  logic [XW-1:0]     x1;
  logic [RCW-1:0]    qe1;
  logic [RCW-1:0]    qe2;
  logic [RMW-1:0]    qd;
  logic [RMW-1:0]    rem2;
  logic [RCW:0]      q_fix;

  // The estimate is the quotient or one short of it; the remainder settles which.
  assign prod  = (XW+RCW)'(x) * (XW+RCW)'(RECIP);
  assign qd    = RMW'(qe1) * DIV_R;
  assign q_fix = (rem2 >= DIV_R) ? ({1'b0, qe2} + (RCW+1)'(1)) : {1'b0, qe2};

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= x;
      qe1  <= prod[XW+RCW-1:XW];
      rem2 <= x1[RMW-1:0] - qd;
      qe2  <= qe1;
      q    <= QW'(q_fix);
    end
  end

endmodule

[rtl/stepper_microstep_phase_drive_unit.sv]
// Top level of the two-phase stepper microstep phase drive.
// Each step transfer carries a signed electrical angle and a coil current in milliamps and
// produces exactly one result: the angle wrapped into 0 to ANGLE_STEPS-1, an 8-bit reference
// DAC level for each coil and an H-bridge code for each coil. The current is saturated to
// MAX_CURRENT_MA, sine and cosine come from a table of ANGLE_STEPS entries held in a
// synchronous ROM that is built at elaboration, so no clearing pass follows reset. The block
// is a stalling pipeline: it takes one step per clock while results are being taken. Each
// step passes from the input register through angle reduction, a ROM read, a current
// product, two constant dividers in series with a scaling stage between them and the output
// register. A one-entry input register lets one more step be taken while a finished result is
// still waiting at the output. A coil whose value is zero keeps its previous bridge code.
// With drive_enable low the levels are zero, both bridges are off and the raw angle is
// returned. Configuration is expected only while no step is in flight.
module stepper_microstep_phase_drive_unit #(
  parameter int ANGLE_STEPS    = 1024,
  parameter int SINE_PEAK      = 32768,
  parameter int MAX_CURRENT_MA = 2500,
  parameter int DAC_FULL       = 255
) (
  input logic           clk,
  input logic           rst,
  smpd_step_if.sink     step_ch,
  smpd_result_if.source result_ch,
  smpd_cfg_if.sink      cfg_ch
);
  import smpd_pkg::*;

  localparam int AW      = $clog2(ANGLE_STEPS);
  localparam int MW      = $clog2(SINE_PEAK + 1);
  localparam int VW      = MW + 1;
  localparam int PW      = CURRENT_W + MW;
  localparam int LW      = CURRENT_W + DAC_W;
  localparam int ST_ROM  = 4;
  localparam int ST_PROD = 5;
  localparam int DEPTH   = 12;

  // Handshake and stall control.
  logic adv;
  logic step_take;

  // Configuration registers.
  logic drive_enable;
  logic forward_rotation;

  // Input register.
  logic                  in_valid_q;
  logic [ANGLE_W-1:0]    in_angle_q;
  logic [CURRENT_W-1:0]  in_cur_q;
  logic [CURRENT_W-1:0]  cur_sat;

  // Pipeline occupancy and side lines carried alongside the arithmetic.
  logic [DEPTH:1]        vld;
  logic [ANGLE_W-1:0]    raw_line [1:DEPTH];
  logic [CURRENT_W-1:0]  cur_line [1:ST_ROM];
  logic [AW-1:0]         wr_line  [ST_ROM:DEPTH];
  bridge_t               code_sin_line [ST_PROD:DEPTH];
  bridge_t               code_cos_line [ST_PROD:DEPTH];

  logic [AW-1:0]         wrapped;
  logic signed [VW-1:0]  rom_sin;
  logic signed [VW-1:0]  rom_cos;
  logic [MW-1:0]         mag_sin;
  logic [MW-1:0]         mag_cos;
  bridge_t               code_sin;
  bridge_t               code_cos;
  logic [PW-1:0]         prod_sin;
  logic [PW-1:0]         prod_cos;
  logic [CURRENT_W-1:0]  ma_sin;
  logic [CURRENT_W-1:0]  ma_cos;
  logic [LW-1:0]         scl_sin;
  logic [LW-1:0]         scl_cos;
  logic [DAC_W-1:0]      lvl_sin;
  logic [DAC_W-1:0]      lvl_cos;

  // Bridge state and output register.
  bridge_t               coil_a_drive;
  bridge_t               coil_b_drive;
  bridge_t               coil_a_next;
  bridge_t               coil_b_next;
  bridge_t               code_b_dir;
  logic                  out_valid;
  logic [ANGLE_W-1:0]    out_wrapped;
  logic [DAC_W-1:0]      out_dac_sine;
  logic [DAC_W-1:0]      out_dac_cosine;

  // The whole pipeline advances together whenever the output register can take a result.
  assign adv           = !out_valid || result_ch.ready;
  assign step_ch.ready = !in_valid_q || adv;
  assign step_take     = step_ch.valid && step_ch.ready;
  assign cfg_ch.ready  = 1'b1;

  assign cur_sat = (step_ch.current_ma > CURRENT_W'(MAX_CURRENT_MA)) ?
                   CURRENT_W'(MAX_CURRENT_MA) : step_ch.current_ma;

  // Register writes; an unknown index is ignored and only bit 0 of the data is used.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_enable     <= 1'b1;
      forward_rotation <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DRIVE_ENABLE:     drive_enable     <= cfg_ch.data[0];
        REG_FORWARD_ROTATION: forward_rotation <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Input register: the current is saturated as the step is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (step_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_take) begin
      in_angle_q <= step_ch.step_angle;
      in_cur_q   <= cur_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-1:1], in_valid_q};
    end
  end

  // Angle reduction, result ready at stage 3.
  smpd_wrap #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .AW          (AW)
  ) u_wrap (
    .clk     (clk),
    .en      (adv),
    .angle   (in_angle_q),
    .wrapped (wrapped)
  );

  // Table read at stage 3, data at stage 4.
  smpd_sine_rom #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .SINE_PEAK   (SINE_PEAK),
    .AW          (AW),
    .VW          (VW)
  ) u_rom (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (wrapped),
    .rd_sin  (rom_sin),
    .rd_cos  (rom_cos)
  );

  assign mag_sin  = MW'((rom_sin < 0) ? -rom_sin : rom_sin);
  assign mag_cos  = MW'((rom_cos < 0) ? -rom_cos : rom_cos);
  assign code_sin = (rom_sin > 0) ? BRIDGE_POS : ((rom_sin < 0) ? BRIDGE_NEG : BRIDGE_OFF);
  assign code_cos = (rom_cos > 0) ? BRIDGE_POS : ((rom_cos < 0) ? BRIDGE_NEG : BRIDGE_OFF);

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_line[1] <= in_angle_q;
      for (int i = 2; i <= DEPTH; i++) begin
        raw_line[i] <= raw_line[i-1];
      end
      cur_line[1] <= in_cur_q;
      for (int i = 2; i <= ST_ROM; i++) begin
        cur_line[i] <= cur_line[i-1];
      end
      wr_line[ST_ROM] <= wrapped;
      for (int i = ST_ROM + 1; i <= DEPTH; i++) begin
        wr_line[i] <= wr_line[i-1];
      end
      code_sin_line[ST_PROD] <= code_sin;
      code_cos_line[ST_PROD] <= code_cos;
      for (int i = ST_PROD + 1; i <= DEPTH; i++) begin
        code_sin_line[i] <= code_sin_line[i-1];
        code_cos_line[i] <= code_cos_line[i-1];
      end
      // Stage 5: current times table magnitude.
      prod_sin <= PW'(cur_line[ST_ROM]) * PW'(mag_sin);
      prod_cos <= PW'(cur_line[ST_ROM]) * PW'(mag_cos);
      // Stage 9: coil current in milliamps times the DAC full scale.
      scl_sin  <= LW'(ma_sin) * LW'(DAC_FULL);
      scl_cos  <= LW'(ma_cos) * LW'(DAC_FULL);
    end
  end

  // Stages 6 to 8: milliamps per coil.
  smpd_cdiv #(.XW(PW), .DIVISOR(SINE_PEAK), .QW(CURRENT_W)) u_div_ma_sin (
    .clk (clk), .en (adv), .x (prod_sin), .q (ma_sin)
  );

  smpd_cdiv #(.XW(PW), .DIVISOR(SINE_PEAK), .QW(CURRENT_W)) u_div_ma_cos (
    .clk (clk), .en (adv), .x (prod_cos), .q (ma_cos)
  );

  // Stages 10 to 12: DAC level. With the current saturated it never exceeds DAC_FULL.
  smpd_cdiv #(.XW(LW), .DIVISOR(MAX_CURRENT_MA), .QW(DAC_W)) u_div_lvl_sin (
    .clk (clk), .en (adv), .x (scl_sin), .q (lvl_sin)
  );

  smpd_cdiv #(.XW(LW), .DIVISOR(MAX_CURRENT_MA), .QW(DAC_W)) u_div_lvl_cos (
    .clk (clk), .en (adv), .x (scl_cos), .q (lvl_cos)
  );

  // Reverse rotation negates the cosine, which swaps the direction of coil B.
  always_comb begin
    code_b_dir = code_cos_line[DEPTH];
    if (!forward_rotation) begin
      unique case (code_cos_line[DEPTH])
        BRIDGE_POS: code_b_dir = BRIDGE_NEG;
        BRIDGE_NEG: code_b_dir = BRIDGE_POS;
        default:    code_b_dir = code_cos_line[DEPTH];
      endcase
    end
  end

  // A zero coil value keeps the previous direction; a disabled step turns both bridges off.
  always_comb begin
    if (!drive_enable) begin
      coil_a_next = BRIDGE_OFF;
      coil_b_next = BRIDGE_OFF;
    end else begin
      coil_a_next = (code_sin_line[DEPTH] == BRIDGE_OFF) ? coil_a_drive : code_sin_line[DEPTH];
      coil_b_next = (code_b_dir == BRIDGE_OFF) ? coil_b_drive : code_b_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      coil_a_drive <= BRIDGE_OFF;
      coil_b_drive <= BRIDGE_OFF;
    end else if (adv) begin
      out_valid <= vld[DEPTH];
      if (vld[DEPTH]) begin
        coil_a_drive <= coil_a_next;
        coil_b_drive <= coil_b_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[DEPTH]) begin
      if (drive_enable) begin
        out_wrapped    <= ANGLE_W'(wr_line[DEPTH]);
        out_dac_sine   <= lvl_sin;
        out_dac_cosine <= lvl_cos;
      end else begin
        out_wrapped    <= raw_line[DEPTH];
        out_dac_sine   <= '0;
        out_dac_cosine <= '0;
      end
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.wrapped_angle = $signed(out_wrapped);
  assign result_ch.dac_sine      = out_dac_sine;
  assign result_ch.dac_cosine    = out_dac_cosine;
  assign result_ch.coil_a_bridge = coil_a_drive;
  assign result_ch.coil_b_bridge = coil_b_drive;

endmodule

[rtl/smpd_checker.sv]
// Port-level assertions on the result channel of the phase drive, bound to the top level.
module smpd_checker #(
  parameter int ANGLE_STEPS = 1024
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [31:0]            wrapped_angle,
  input logic [7:0]                    dac_sine,
  input logic [7:0]                    dac_cosine,
  input smpd_pkg::bridge_t             coil_a_bridge,
  input smpd_pkg::bridge_t             coil_b_bridge
);
  import smpd_pkg::*;

  // A result that is not taken stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(wrapped_angle) && $stable(dac_sine) &&
      $stable(dac_cosine) && $stable(coil_a_bridge) && $stable(coil_b_bridge))
    else $error("result payload changed while stalled");

  // An idle bridge means the coil has seen no non-zero value since reset or the last disable.
  a_coil_a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && coil_a_bridge == BRIDGE_OFF |-> dac_sine == 8'd0)
    else $error("coil A level without a bridge direction");

  a_coil_b_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && coil_b_bridge == BRIDGE_OFF |-> dac_cosine == 8'd0)
    else $error("coil B level without a bridge direction");

  // A driven bridge implies an enabled step, whose angle lies in one period.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (coil_a_bridge != BRIDGE_OFF || coil_b_bridge != BRIDGE_OFF) |->
      wrapped_angle >= 0 && wrapped_angle < ANGLE_STEPS)
    else $error("driven result with an angle outside one period");

endmodule

bind stepper_microstep_phase_drive_unit smpd_checker #(
  .ANGLE_STEPS (ANGLE_STEPS)
) u_smpd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result_ch.valid),
  .out_ready     (result_ch.ready),
  .wrapped_angle (result_ch.wrapped_angle),
  .dac_sine      (result_ch.dac_sine),
  .dac_cosine    (result_ch.dac_cosine),
  .coil_a_bridge (result_ch.coil_a_bridge),
  .coil_b_bridge (result_ch.coil_b_bridge)
);

[dv/smpd_drive_checker.sv]
// Checker that predicts each phase drive result from the observed transfers and compares it.
`timescale 1ns / 1ps
module smpd_drive_checker #(
  parameter int ANGLE_STEPS    = 1024,
  parameter int SINE_PEAK      = 32768,
  parameter int MAX_CURRENT_MA = 2500,
  parameter int DAC_FULL       = 255
) (
  input  logic   clk,
  input  logic   rst,
  smpd_step_if   step_ch,
  smpd_result_if result_ch,
  smpd_cfg_if    cfg_ch,
  output int     fail_count,
  output int     drives_pending
);
  import smpd_pkg::*;

  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam int              REPORT_MAX  = 10;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] wrapped_angle;
    logic [DAC_W-1:0]          dac_sine;
    logic [DAC_W-1:0]          dac_cosine;
    bridge_t                   coil_a_bridge;
    bridge_t                   coil_b_bridge;
  } drive_result_t;

  logic          enable_q;
  logic          forward_q;
  bridge_t       coil_a_q;
  bridge_t       coil_b_q;
  drive_result_t expected_drives[$];
  int            mismatches = 0;

  // Truncated Taylor series in Q30, odd terms for the sine and even terms for the cosine.
  function automatic longint taylor_q30(input longint unsigned x, input bit odd_series);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint          acc;
    x2   = (x * x) >> 30;
    term = odd_series ? x : ONE_Q30;
    acc  = longint'(term);
    for (int n = 1; n <= 6; n++) begin
      den  = odd_series ? 64'(2 * n * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = ((term * x2) >> 30) / den;
      if (n % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    return acc;
  endfunction

  // Signed table value of angle k, moved on by the given number of quarter periods.
  function automatic int table_sine(input int unsigned k, input int unsigned shift);
    longint unsigned four_k;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned x;
    longint unsigned mag;
    longint          base;
    longint          co;
    longint          v;
    bit              lower;
    four_k = 64'(k) * 4;
    quad   = (four_k / ANGLE_STEPS + shift) & 3;
    rem    = four_k % ANGLE_STEPS;
    lower  = (2 * rem <= ANGLE_STEPS);
    if (lower) begin
      x = (PI_HALF_Q30 * rem) / ANGLE_STEPS;
    end else begin
      x = (PI_HALF_Q30 * (ANGLE_STEPS - rem)) / ANGLE_STEPS;
    end
    base = taylor_q30(x, lower);
    co   = taylor_q30(x, !lower);
    v    = quad[0] ? co : base;
    if (v < 0) begin
      v = 0;
    end
    mag = (unsigned'(v) * SINE_PEAK + ONE_Q30 / 2) >> 30;
    if (mag > SINE_PEAK) begin
      mag = SINE_PEAK;
    end
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic [DAC_W-1:0] dac_code(input int unsigned amps, input int coil);
    longint unsigned mag;
    longint unsigned ma;
    longint unsigned lvl;
    mag = (coil < 0) ? unsigned'(-longint'(coil)) : unsigned'(longint'(coil));
    ma  = (amps * mag) / SINE_PEAK;
    lvl = (ma * DAC_FULL) / MAX_CURRENT_MA;
    if (lvl > 255) begin
      lvl = 255;
    end
    return lvl[DAC_W-1:0];
  endfunction

  // A coil at zero keeps whatever direction its bridge had.
  function automatic bridge_t coil_code(input int coil, input bridge_t prev);
    if (coil > 0) begin
      return BRIDGE_POS;
    end else if (coil < 0) begin
      return BRIDGE_NEG;
    end
    return prev;
  endfunction

  // Works out the result of one step and moves the bridge state on.
  function automatic drive_result_t predict_drive(input logic signed [ANGLE_W-1:0] angle,
                                                  input logic [CURRENT_W-1:0] current);
    drive_result_t r;
    int unsigned   amps;
    longint        folded;
    int            sin_v;
    int            cos_v;
    amps = (current > MAX_CURRENT_MA) ? MAX_CURRENT_MA : current;
    if (!enable_q) begin
      coil_a_q        = BRIDGE_OFF;
      coil_b_q        = BRIDGE_OFF;
      r.wrapped_angle = angle;
      r.dac_sine      = '0;
      r.dac_cosine    = '0;
      r.coil_a_bridge = BRIDGE_OFF;
      r.coil_b_bridge = BRIDGE_OFF;
      return r;
    end
    folded = longint'(angle) % ANGLE_STEPS;
    if (folded < 0) begin
      folded += ANGLE_STEPS;
    end
    sin_v = table_sine(unsigned'(32'(folded)), 0);
    cos_v = table_sine(unsigned'(32'(folded)), 1);
    if (!forward_q) begin
      cos_v = -cos_v;
    end
    coil_a_q        = coil_code(sin_v, coil_a_q);
    coil_b_q        = coil_code(cos_v, coil_b_q);
    r.wrapped_angle = folded[ANGLE_W-1:0];
    r.dac_sine      = dac_code(amps, sin_v);
    r.dac_cosine    = dac_code(amps, cos_v);
    r.coil_a_bridge = coil_a_q;
    r.coil_b_bridge = coil_b_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    drive_result_t got;
    drive_result_t want;
    if (rst) begin
      enable_q  = 1'b1;
      forward_q = 1'b1;
      coil_a_q  = BRIDGE_OFF;
      coil_b_q  = BRIDGE_OFF;
      expected_drives.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_DRIVE_ENABLE) begin
          enable_q = cfg_ch.data[0];
        end else if (cfg_ch.index == REG_FORWARD_ROTATION) begin
          forward_q = cfg_ch.data[0];
        end
      end
      // Results are retired before the step of the same edge is queued.
      if (result_ch.valid && result_ch.ready) begin
        got.wrapped_angle = result_ch.wrapped_angle;
        got.dac_sine      = result_ch.dac_sine;
        got.dac_cosine    = result_ch.dac_cosine;
        got.coil_a_bridge = result_ch.coil_a_bridge;
        got.coil_b_bridge = result_ch.coil_b_bridge;
        if (expected_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: result with none expected: angle %0d dac %0d/%0d bridge %0d/%0d",
                     $realtime, got.wrapped_angle, got.dac_sine, got.dac_cosine,
                     got.coil_a_bridge, got.coil_b_bridge);
          end
        end else begin
          want = expected_drives.pop_front();
          if (got.wrapped_angle !== want.wrapped_angle || got.dac_sine !== want.dac_sine ||
              got.dac_cosine !== want.dac_cosine || got.coil_a_bridge !== want.coil_a_bridge ||
              got.coil_b_bridge !== want.coil_b_bridge) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: expected angle %0d dac %0d/%0d bridge %0d/%0d", $realtime,
                       want.wrapped_angle, want.dac_sine, want.dac_cosine,
                       want.coil_a_bridge, want.coil_b_bridge);
              $display("%0t:   actual angle %0d dac %0d/%0d bridge %0d/%0d", $realtime,
                       got.wrapped_angle, got.dac_sine, got.dac_cosine,
                       got.coil_a_bridge, got.coil_b_bridge);
            end
          end
        end
      end
      if (step_ch.valid && step_ch.ready) begin
        expected_drives.push_back(predict_drive(step_ch.step_angle, step_ch.current_ma));
      end
    end
    fail_count     <= mismatches;
    drives_pending <= expected_drives.size();
  end

endmodule

[dv/tb.sv]
// Testbench top: drives step and register transfers into the phase drive and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import smpd_pkg::*;

  // The receiver's long hold-off, enough to fill the pipeline and back-pressure the input.
  localparam int HOLD_OFF_CYCLES = 200;
  // Cycles without any transfer before the run is declared hung. The slowest correct
  // stretch is the hold-off above plus a drain of the pipeline.
  localparam int STALL_LIMIT     = 4000;
  // Quiet cycles after the last result, to catch anything the block emits unasked.
  localparam int TAIL_CYCLES     = 40;
  localparam int PHASE_ITEMS     = 110;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   drives_pending;
  int   quiet_cycles = 0;
  bit   idling_on;
  bit   hold_off_due;
  logic signed [ANGLE_W-1:0] rotor_angle;

  smpd_step_if   step_ch();
  smpd_result_if result_ch();
  smpd_cfg_if    cfg_ch();

  always #10 clk = ~clk;

  stepper_microstep_phase_drive_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .step_ch   (step_ch),
    .result_ch (result_ch),
    .cfg_ch    (cfg_ch)
  );

  smpd_drive_checker u_drive_checker (
    .clk            (clk),
    .rst            (rst),
    .step_ch        (step_ch),
    .result_ch      (result_ch),
    .cfg_ch         (cfg_ch),
    .fail_count     (fail_count),
    .drives_pending (drives_pending)
  );

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (step_ch.valid && step_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. Each pass makes exactly one assignment to ready and then lets at least
  // one edge go by, so ready never sees two updates in one time step. A requested
  // hold-off is counted here, so the sender carries on offering steps meanwhile.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offers one step and returns at the edge of its transfer with valid still high, so a
  // following step can go out back to back. A gap, when there is one, comes first.
  task automatic push_step(input logic signed [ANGLE_W-1:0] angle,
                           input logic [CURRENT_W-1:0] amps);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      step_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    step_ch.valid      <= 1'b1;
    step_ch.step_angle <= angle;
    step_ch.current_ma <= amps;
    do @(posedge clk); while (!step_ch.ready);
  endtask

  // Stops offering steps and waits until every result still owed has been taken. The
  // checker's count is registered and so lags behind, which can only make the wait longer.
  task automatic drain_results();
    step_ch.valid <= 1'b0;
    do @(posedge clk); while (drives_pending != 0);
  endtask

  // One register write; valid is lowered at the edge of the transfer and the task waits for
  // another edge before it returns, so two writes in a row never touch valid twice in one time step.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the pipeline empty. Only bit 0 of the data matters, so
  // the upper bits are random; now and then a write to an unused index goes out as well,
  // which the block must ignore.
  task automatic set_mode(input bit enable, input bit forward);
    drain_results();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_INDEX_W'($urandom_range(2, 255)), $urandom);
    end
    write_reg(REG_DRIVE_ENABLE, {31'($urandom), enable});
    write_reg(REG_FORWARD_ROTATION, {31'($urandom), forward});
  endtask

  // Random part. Most steps follow a rotor moving a few microsteps at a time, which is
  // how the block is used and which walks it across quadrant boundaries and zero
  // crossings; the rest are quarter-period points, full-range words and angles at the
  // ends of the signed range. Currents mostly lie between zero and just above the limit.
  task automatic run_motion(input int items);
    logic signed [ANGLE_W-1:0] angle;
    logic [CURRENT_W-1:0]      amps;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          rotor_angle = rotor_angle + int'($urandom_range(0, 16)) - 8;
          angle       = rotor_angle;
        end
        6: begin
          angle = $urandom;
        end
        7: begin
          angle = ($urandom & ~32'h3FF) | ($urandom_range(0, 3) << 8);
        end
        8: begin
          rotor_angle = $urandom;
          angle       = rotor_angle;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            angle = 32'h7FFF_FFFF - $urandom_range(0, 1100);
          end else begin
            angle = 32'h8000_0000 + $urandom_range(0, 1100);
          end
        end
      endcase
      case ($urandom_range(0, 9))
        7:       amps = CURRENT_W'($urandom);
        8:       amps = 16'd2500;
        9:       amps = '0;
        default: amps = CURRENT_W'($urandom_range(0, 2600));
      endcase
      push_step(angle, amps);
    end
  endtask

  initial begin
    rst                <= 1'b1;
    step_ch.valid      <= 1'b0;
    step_ch.step_angle <= '0;
    step_ch.current_ma <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    idling_on    = 1'b1;
    hold_off_due = 1'b0;
    rotor_angle  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part in the reset mode: the quarter-period points where one coil is at
    // zero and must keep its previous bridge (off straight after reset), the wrap at
    // both ends of the period and of the signed range, and currents at, just around and
    // far above the limit.
    push_step(0, 0);
    push_step(0, 2500);
    push_step(256, 2500);
    push_step(512, 2500);
    push_step(768, 2500);
    push_step(1023, 2499);
    push_step(1024, 2501);
    push_step(-1, 16'hFFFF);
    push_step(-1024, 1000);
    push_step(32'sh7FFF_FFFF, 2500);
    push_step(32'sh8000_0000, 2500);
    push_step(128, 2500);
    push_step(1, 1);
    push_step(255, 2500);
    push_step(257, 2500);
    push_step(511, 2500);
    push_step(513, 2500);

    // Long receiver hold-off while steps keep coming without gaps, so the block fills up
    // and has to stall its input.
    idling_on    = 1'b0;
    hold_off_due = 1'b1;
    run_motion(40);
    idling_on = 1'b1;

    // Drive disabled: zero levels, bridges off and the raw angle returned. A write to an
    // unused index with all bits set must leave it disabled.
    set_mode(1'b0, 1'b1);
    push_step(32'sh8000_0000, 16'hFFFF);
    push_step(-5, 100);
    drain_results();
    write_reg(8'd2, 32'hFFFF_FFFF);
    push_step(256, 2500);

    // Reversed rotation, starting with both bridges off after the disabled steps.
    set_mode(1'b1, 1'b0);
    push_step(512, 2500);
    push_step(0, 2500);
    push_step(256, 2500);
    push_step(768, 2500);

    // Random phases through every register setting; one in the middle and the last run
    // without any idling.
    set_mode(1'b1, 1'b1);
    run_motion(PHASE_ITEMS);
    set_mode(1'b1, 1'b0);
    run_motion(PHASE_ITEMS);
    set_mode(1'b0, 1'b0);
    run_motion(PHASE_ITEMS);
    idling_on = 1'b0;
    set_mode(1'b1, 1'b1);
    run_motion(PHASE_ITEMS);
    idling_on = 1'b1;
    set_mode(1'b0, 1'b1);
    run_motion(PHASE_ITEMS);
    set_mode(1'b1, 1'b0);
    run_motion(PHASE_ITEMS);
    idling_on = 1'b0;
    set_mode(1'b1, 1'b1);
    run_motion(PHASE_ITEMS);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && drives_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
